### rtl/sqn_pkg.sv
// shared widths and defaults for the newton square root block
package sqn_pkg;

  localparam int RAD_W       = 32;
  localparam int ROOT_W      = 24;
  localparam int EPS_W       = 16;

  localparam int DEF_MAX_ITERATIONS = 32;
  localparam int DEF_FRAC_BITS      = 16;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

endpackage

### rtl/sqn_intf.sv
// request and result channel interfaces for the newton square root block
interface sqn_req_if import sqn_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [RAD_W-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface sqn_res_if import sqn_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root;
  logic              invalid;
  logic              hit_limit;

  modport source (output valid, output root, output invalid, output hit_limit, input ready);
  modport sink   (input valid, input root, input invalid, input hit_limit, output ready);
endinterface

### rtl/sqn_div.sv
// restoring divider, one quotient bit per cycle
module sqn_div import sqn_pkg::*; #(
  parameter int W = RAD_W - 1 + DEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [W:0]   shifted;
  logic [W+1:0] trial;
  logic         neg;

  always_comb begin
    shifted = {rem, quo[W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs};
    neg     = trial[W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= CNT_W'(W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= neg ? shifted[W-1:0] : trial[W-1:0];
        quo <= {quo[W-2:0], ~neg};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### rtl/square_root_newton.sv
// Babylonian square root of a signed fixed-point radicand.
// A request carries one signed radicand with FRAC_BITS fraction bits; the
// result carries its unsigned root (same format, saturated to 24 bits), an
// invalid flag for a negative radicand, and hit_limit when the iteration
// stopped at MAX_ITERATIONS instead of converging within epsilon.
// epsilon is to be written through cfg_we / cfg_data only while the block is
// idle; the block itself does not enforce this. One request at a time:
// request.ready is high only when the block is idle. Negative and zero
// radicands skip the iteration and go straight to the result. Otherwise each
// Newton step takes one check state plus a restoring division of 31 +
// FRAC_BITS bits (47 at Q16.16) in the single divider. Typical radicands
// take 10 to 20 steps, at most MAX_ITERATIONS steps.
// The result stays on the result channel until it is taken; a stalled
// receiver holds the block and no new request is accepted meanwhile.
// Synchronous reset returns to idle, drops result.valid and sets epsilon to 1.
module square_root_newton import sqn_pkg::*; #(
  parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS,
  parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  sqn_req_if.sink          request,
  sqn_res_if.source        result,
  input  logic             cfg_we,
  input  logic [EPS_W-1:0] cfg_data
);

  localparam int NUM_W  = RAD_W - 1 + FRAC_BITS;
  localparam int STEP_W = $clog2(MAX_ITERATIONS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_DONE
  } state_t;

  state_t            state;
  logic [EPS_W-1:0]  epsilon;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  prev;
  logic [NUM_W-1:0]  est;
  logic [STEP_W-1:0] steps;
  logic              div_start;
  logic [NUM_W-1:0]  div_divisor;
  logic              div_done;
  logic [NUM_W-1:0]  div_quotient;
  logic [ROOT_W-1:0] root_q;
  logic              invalid_q;
  logic              limit_q;

  logic [NUM_W-1:0]  diff;
  logic              converged;
  logic [NUM_W:0]    est_sum;
  logic [ROOT_W-1:0] root_sat;

  sqn_div #(.W(NUM_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    diff      = (prev > est) ? (prev - est) : (est - prev);
    converged = diff <= NUM_W'(epsilon);
    est_sum   = {1'b0, prev} + {1'b0, div_quotient};
    // saturate an estimate that has not come down into the root range yet
    root_sat  = (est > NUM_W'({ROOT_W{1'b1}})) ? {ROOT_W{1'b1}} : est[ROOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (cfg_we) begin
      epsilon <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      steps     <= '0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (request.valid) begin
            root_q    <= '0;
            invalid_q <= 1'b0;
            limit_q   <= 1'b0;
            num       <= {request.radicand[RAD_W-2:0], {FRAC_BITS{1'b0}}};
            prev      <= '0;
            est       <= NUM_W'(1) << FRAC_BITS;
            steps     <= '0;
            if (request.radicand[RAD_W-1]) begin
              invalid_q <= 1'b1;
              state     <= S_DONE;
            end else if (request.radicand == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (converged) begin
            root_q <= root_sat;
            state  <= S_DONE;
          end else if (steps == STEP_W'(MAX_ITERATIONS)) begin
            root_q  <= root_sat;
            limit_q <= 1'b1;
            state   <= S_DONE;
          end else begin
            prev        <= est;
            div_divisor <= (est == '0) ? NUM_W'(1) : est;
            div_start   <= 1'b1;
            state       <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            est   <= est_sum[NUM_W:1];
            steps <= steps + STEP_W'(1);
            state <= S_CHECK;
          end
        end
        S_DONE: begin
          if (result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign request.ready    = (state == S_IDLE);
  assign result.valid     = (state == S_DONE);
  assign result.root      = root_q;
  assign result.invalid   = invalid_q;
  assign result.hit_limit = limit_q;

endmodule

### verif/tb_square_root_newton.sv
// self-checking testbench for the newton square root block
module tb_square_root_newton;
  import sqn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_STEPS      = DEF_MAX_ITERATIONS;
  localparam int FRAC           = DEF_FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 60;
  localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              invalid;
    logic              hit_limit;
  } root_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_t;

  class root_scoreboard;
    logic [EPS_W-1:0] epsilon;
    root_result_t     pending_roots[$];
    int unsigned      errors;

    function new();
      epsilon = EPS_RESET;
      errors  = 0;
    endfunction

    function void set_epsilon(logic [EPS_W-1:0] value);
      epsilon = value;
    endfunction

    // newton iteration from 1.0, truncating divide and halve
    function root_result_t predict_root(logic signed [RAD_W-1:0] rad);
      logic [63:0] num, prev, est, divisor, diff;
      int steps;
      root_result_t r;
      r = '0;
      if (rad < 0) begin
        r.invalid = 1'b1;
      end else if (rad != 0) begin
        num   = 64'(rad) << FRAC;
        prev  = '0;
        est   = 64'(1) << FRAC;
        steps = 0;
        forever begin
          diff = (prev > est) ? prev - est : est - prev;
          if (diff <= 64'(epsilon)) break;
          if (steps >= MAX_STEPS) begin
            r.hit_limit = 1'b1;
            break;
          end
          prev    = est;
          divisor = (prev == 0) ? 64'(1) : prev;
          est     = (prev + num / divisor) >> 1;
          steps++;
        end
        r.root = (est > 64'(ROOT_MAX)) ? ROOT_MAX : est[ROOT_W-1:0];
      end
      return r;
    endfunction

    function void note_request(logic signed [RAD_W-1:0] rad);
      pending_roots.push_back(predict_root(rad));
    endfunction

    function void check_result(logic [ROOT_W-1:0] root, logic invalid, logic hit_limit);
      root_result_t want;
      if (pending_roots.size() == 0) begin
        $display("%0t: result with nothing pending: root %h invalid %b hit_limit %b",
                 $time, root, invalid, hit_limit);
        errors++;
        return;
      end
      want = pending_roots.pop_front();
      if (root !== want.root) begin
        $display("%0t: root mismatch: expected %h actual %h", $time, want.root, root);
        errors++;
      end
      if (invalid !== want.invalid) begin
        $display("%0t: invalid mismatch: expected %b actual %b", $time, want.invalid, invalid);
        errors++;
      end
      if (hit_limit !== want.hit_limit) begin
        $display("%0t: hit_limit mismatch: expected %b actual %b",
                 $time, want.hit_limit, hit_limit);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [EPS_W-1:0] cfg_data;

  sqn_req_if req_ch();
  sqn_res_if res_ch();

  root_scoreboard sb = new();
  int burst_left;

  square_root_newton #(
    .MAX_ITERATIONS(MAX_STEPS),
    .FRAC_BITS     (FRAC)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // observe both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.radicand);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.root, res_ch.invalid, res_ch.hit_limit);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: alternates between always ready, coin flips and long stalls
  initial begin
    stall_mode_t mode;
    int mode_left;
    res_ch.ready = 1'b0;
    mode = STALL_NONE;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (mode)
        STALL_NONE:   res_ch.ready <= 1'b1;
        STALL_RANDOM: res_ch.ready <= 1'($urandom_range(0, 1));
        default:      res_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic logic signed [RAD_W-1:0] random_radicand();
    int unsigned kind, w, k;
    logic [RAD_W-1:0] v;
    kind = $urandom_range(0, 19);
    if (kind < 4) begin
      v = $urandom | 32'h8000_0000;
    end else if (kind == 4) begin
      case ($urandom_range(0, 4))
        0: v = 32'h0000_0000;
        1: v = 32'h0000_0001;
        2: v = 32'h7FFF_FFFF;
        3: v = 32'h0001_0000;
        default: v = 32'h8000_0000;
      endcase
    end else if (kind < 7) begin
      k = $urandom_range(1, 46340);
      v = k * k;
    end else begin
      // spread magnitudes over all widths, not just large values
      w = $urandom_range(1, RAD_W - 1);
      v = $urandom & ((32'h1 << w) - 1);
    end
    return v;
  endfunction

  task automatic send_radicand(input logic signed [RAD_W-1:0] rad);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.radicand <= rad;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_roots.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_epsilon(input logic [EPS_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_epsilon(value);
  endtask

  initial begin
    logic signed [RAD_W-1:0] directed[$];
    logic [EPS_W-1:0] eps;
    int count;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.radicand = '0;
    burst_left      = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // field extremes, zero, negatives and exact squares at the reset epsilon
    directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0004,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
                 32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0001_8000,
                 32'h0064_0000, 32'h0000_FFFF, 32'h7FFF_0000, 32'h4000_0000,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h0000_0100};
    foreach (directed[i]) send_radicand(directed[i]);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       eps = 16'd1;
        1:       eps = 16'd0;
        2:       eps = 16'hFFFF;
        3:       eps = 16'd2;
        4:       eps = EPS_W'($urandom_range(3, 64));
        5:       eps = EPS_W'($urandom_range(1, 65535));
        6:       eps = 16'd16;
        default: eps = 16'd1;
      endcase
      // a zero epsilon can run items to the step limit, so keep it short
      count = (ph == 1) ? 24 : 127;
      wait_all_results();
      write_epsilon(eps);
      repeat (count) begin
        if ($urandom_range(0, 59) == 0) wait_all_results();
        send_radicand(random_radicand());
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.pending_roots.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_roots.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
rtl/sqn_pkg.sv
rtl/sqn_intf.sv
rtl/sqn_div.sv
rtl/square_root_newton.sv
verif/tb_square_root_newton.sv
